// ===== rtl/chunked_base64_transfer_receiver_unit_macros.svh =====
// assertion macros for the chunked base64 transfer receiver
`ifndef CHUNKED_BASE64_TRANSFER_RECEIVER_UNIT_MACROS_SVH
`define CHUNKED_BASE64_TRANSFER_RECEIVER_UNIT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`ifndef SYNTH
`define CBTR_ASSERT_SAME(lbl, clk, rst_n, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("same-cycle check failed");
`else
`define CBTR_ASSERT_SAME(lbl, clk, rst_n, trig, prop)
`endif

// property that must hold in the cycle after its trigger
`ifndef SYNTH
`define CBTR_ASSERT_NEXT(lbl, clk, rst_n, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define CBTR_ASSERT_NEXT(lbl, clk, rst_n, trig, prop)
`endif

`endif

// ===== rtl/cbtr_pkg.sv =====
// shared types and codes of the chunked base64 transfer receiver
package cbtr_pkg;

    // request kinds
    localparam logic [2:0] ACT_BEGIN  = 3'd0;
    localparam logic [2:0] ACT_GROUP  = 3'd1;
    localparam logic [2:0] ACT_EMPTY  = 3'd2;
    localparam logic [2:0] ACT_FINISH = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NO_XFER    = 3'd3;
    localparam logic [2:0] ST_ORDER      = 3'd4;
    localparam logic [2:0] ST_BAD64      = 3'd5;
    localparam logic [2:0] ST_INCOMPLETE = 3'd6;
    localparam logic [2:0] ST_MISMATCH   = 3'd7;

    // base64 alphabet markers
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] OFS_LOWER  = 8'd26;
    localparam logic [7:0] OFS_DIGIT  = 8'd52;
    localparam logic [5:0] VAL_PLUS   = 6'd62;
    localparam logic [5:0] VAL_SLASH  = 6'd63;
    localparam logic [2:0] FULL_GROUP = 3'd4;

    // one decoded character
    typedef struct packed {
        logic [5:0] val;
        logic       ok;
        logic       pad;
    } t_lane;

    // what one character group produces
    typedef struct packed {
        logic [2:0] status;
        logic [1:0] nbytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } t_group;

    // one result item
    typedef struct packed {
        logic        complete;
        logic        open;
        logic [15:0] chunks;
        logic [15:0] addr;
        logic [7:0]  byte2;
        logic [7:0]  byte1;
        logic [7:0]  byte0;
        logic [1:0]  nbytes;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== rtl/cbtr_lane.sv =====
// one character lane: base64 symbol decode and validity
module cbtr_lane (
    input  logic [7:0]     i_char,
    output cbtr_pkg::t_lane o_lane
);
    import cbtr_pkg::*;

    // map the ascii character to its six-bit value
    always_comb begin
        o_lane.val = 6'd0;
        o_lane.ok  = 1'b1;
        o_lane.pad = (i_char == CHAR_PAD);
        if (i_char inside {[8'h41:8'h5A]}) begin
            o_lane.val = 6'(i_char - 8'h41);
        end else if (i_char inside {[8'h61:8'h7A]}) begin
            o_lane.val = 6'(i_char - 8'h61 + OFS_LOWER);
        end else if (i_char inside {[8'h30:8'h39]}) begin
            o_lane.val = 6'(i_char - 8'h30 + OFS_DIGIT);
        end else if (i_char == CHAR_PLUS) begin
            o_lane.val = VAL_PLUS;
        end else if (i_char == CHAR_SLASH) begin
            o_lane.val = VAL_SLASH;
        end else if (i_char == CHAR_PAD) begin
            o_lane.val = 6'd0;
        end else begin
            o_lane.ok = 1'b0;
        end
    end

endmodule

// ===== rtl/cbtr_merge.sv =====
// merge stage: combines the four lanes into checked, packed group bytes
module cbtr_merge (
    input  cbtr_pkg::t_lane  i_lane [4],
    input  logic [2:0]       i_char_count,
    input  logic             i_open,
    input  logic             i_order_ok,
    input  logic [1:0]       i_room,
    output cbtr_pkg::t_group o_group
);
    import cbtr_pkg::*;

    logic [7:0] raw0, raw1, raw2;
    logic [7:0] pk1, pk2;
    logic       keep1, keep2;
    logic [1:0] kept;
    logic       all_ok;

    // bytes from the four six-bit values
    assign raw0  = {i_lane[0].val, i_lane[1].val[5:4]};
    assign raw1  = {i_lane[1].val[3:0], i_lane[2].val[5:2]};
    assign raw2  = {i_lane[2].val[1:0], i_lane[3].val};
    assign keep1 = !i_lane[2].pad;
    assign keep2 = !i_lane[3].pad;
    assign kept  = 2'd1 + {1'b0, keep1} + {1'b0, keep2};
    assign all_ok = i_lane[0].ok && i_lane[1].ok && i_lane[2].ok && i_lane[3].ok;

    // kept bytes packed to the front
    assign pk1 = keep1 ? raw1 : raw2;
    assign pk2 = raw2;

    // checks in priority order, then the room limit
    always_comb begin
        o_group.status = ST_OK;
        o_group.nbytes = 2'd0;
        o_group.byte0  = 8'd0;
        o_group.byte1  = 8'd0;
        o_group.byte2  = 8'd0;
        if (!i_open) begin
            o_group.status = ST_NO_XFER;
        end else if (!i_order_ok) begin
            o_group.status = ST_ORDER;
        end else if (i_char_count != FULL_GROUP || !all_ok) begin
            o_group.status = ST_BAD64;
        end else begin
            if (i_room < kept) begin
                o_group.status = ST_FULL;
                o_group.nbytes = i_room;
            end else begin
                o_group.nbytes = kept;
            end
            o_group.byte0 = (o_group.nbytes >= 2'd1) ? raw0 : 8'd0;
            o_group.byte1 = (o_group.nbytes >= 2'd2) ? pk1 : 8'd0;
            o_group.byte2 = (o_group.nbytes == 2'd3) ? pk2 : 8'd0;
        end
    end

endmodule

// ===== rtl/chunked_base64_transfer_receiver_unit.sv =====
// top level of the chunked base64 transfer receiver
//
// Input stream (s side): one request per beat. tuser carries the action
// (begin, character group, empty chunk, finish, clear); tlast marks the group
// that ends its chunk; tdata carries sizes, chunk number, four characters and
// the character count. Output stream (m side): exactly one result per request,
// with status, up to three decoded bytes, their buffer address, the chunk
// count and the transfer and completion flags.
// Four decode lanes handle the characters of a group in parallel and a merge
// stage packs and checks the bytes; the state registers update in the cycle
// of acceptance, so one request is taken every cycle while the skid register is empty.
// The result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one request per cycle while the output side takes results.
// When the output stalls, one further request is accepted into a skid
// register; tready then drops until the output drains.
// Reset (and the clear action) empties the transfer state; reset also
// drops any pending results.
module chunked_base64_transfer_receiver_unit #(
    parameter int MAX_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // total_size[19:0], chunk_total[35:20], chunk_index[51:36],
    // char_first[59:52], char_second[67:60], char_third[75:68],
    // char_fourth[83:76], char_count[86:84], zero[87]
    input  logic [87:0] i_s_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[2:0], byte_count[4:3], byte_first[12:5], byte_second[20:13],
    // byte_third[28:21], write_address[44:29], chunks_done[60:45],
    // transfer_open[61], data_complete[62], zero[63]
    output logic [63:0] o_m_tdata
);
    import cbtr_pkg::*;

    `include "chunked_base64_transfer_receiver_unit_macros.svh"

    localparam int CW = $clog2(MAX_BYTES + 1);

    // input fields
    logic [19:0] in_size;
    logic [15:0] in_chunks, in_index;
    logic [7:0]  in_char [4];
    logic [2:0]  in_count;
    logic [2:0]  in_action;
    logic        accept;

    assign in_size    = i_s_tdata[19:0];
    assign in_chunks  = i_s_tdata[35:20];
    assign in_index   = i_s_tdata[51:36];
    assign in_char[0] = i_s_tdata[59:52];
    assign in_char[1] = i_s_tdata[67:60];
    assign in_char[2] = i_s_tdata[75:68];
    assign in_char[3] = i_s_tdata[83:76];
    assign in_count   = i_s_tdata[86:84];
    assign in_action  = i_s_tuser;

    // transfer state
    logic [CW-1:0] r_exp_bytes, n_exp_bytes;
    logic [CW-1:0] r_written, n_written;
    logic [15:0]   r_exp_chunks, n_exp_chunks;
    logic [15:0]   r_rcv_chunks, n_rcv_chunks;
    logic          r_open, n_open;
    logic          r_drop, n_drop;
    logic [2:0]    r_drop_code, n_drop_code;
    logic          r_complete, n_complete;

    // output register and skid stage
    t_result r_out, n_out, r_skid, n_skid, res;
    logic    r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;

    // decode lanes
    t_lane  lane [4];
    t_group grp;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        cbtr_lane u_lane (
            .i_char (in_char[g]),
            .o_lane (lane[g])
        );
    end

    // room left in the declared size, saturated at one full group
    logic [CW-1:0]    room;
    logic [1:0]       room_sat;
    logic [CW+15:0]   addr_ext;

    assign room     = r_exp_bytes - r_written;
    assign room_sat = (room >= CW'(3)) ? 2'd3 : room[1:0];
    assign addr_ext = {16'd0, r_written};

    cbtr_merge u_merge (
        .i_lane       (lane),
        .i_char_count (in_count),
        .i_open       (r_open),
        .i_order_ok   (in_index == r_rcv_chunks),
        .i_room       (room_sat),
        .o_group      (grp)
    );

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;

    // next transfer state and result of the current request
    always_comb begin
        n_exp_bytes  = r_exp_bytes;
        n_written    = r_written;
        n_exp_chunks = r_exp_chunks;
        n_rcv_chunks = r_rcv_chunks;
        n_open       = r_open;
        n_drop       = r_drop;
        n_drop_code  = r_drop_code;
        n_complete   = r_complete;
        res          = '0;
        case (in_action)
            ACT_GROUP: begin
                res.addr = addr_ext[15:0];
                if (r_drop) begin
                    res.status = r_drop_code;
                    if (i_s_tlast) begin
                        n_drop = 1'b0;
                    end
                end else begin
                    res.status = grp.status;
                    res.nbytes = grp.nbytes;
                    res.byte0  = grp.byte0;
                    res.byte1  = grp.byte1;
                    res.byte2  = grp.byte2;
                    n_written  = r_written + CW'(grp.nbytes);
                    if (grp.status == ST_OK) begin
                        if (i_s_tlast) begin
                            n_rcv_chunks = r_rcv_chunks + 16'd1;
                        end
                    end else if (!i_s_tlast) begin
                        n_drop      = 1'b1;
                        n_drop_code = grp.status;
                    end
                end
            end
            ACT_BEGIN: begin
                n_drop = 1'b0;
                if (in_size == 20'd0 || in_chunks == 16'd0) begin
                    res.status = ST_INVALID;
                end else if ({1'b0, in_size} > 21'(MAX_BYTES)) begin
                    res.status = ST_FULL;
                end else begin
                    n_written    = '0;
                    n_exp_bytes  = CW'(in_size);
                    n_exp_chunks = in_chunks;
                    n_rcv_chunks = 16'd0;
                    n_complete   = 1'b0;
                    n_open       = 1'b1;
                end
            end
            ACT_EMPTY: begin
                n_drop = 1'b0;
                if (!r_open) begin
                    res.status = ST_NO_XFER;
                end else if (in_index != r_rcv_chunks) begin
                    res.status = ST_ORDER;
                end else begin
                    n_rcv_chunks = r_rcv_chunks + 16'd1;
                end
            end
            ACT_FINISH: begin
                n_drop = 1'b0;
                if (!r_open) begin
                    res.status = ST_NO_XFER;
                end else if (r_rcv_chunks != r_exp_chunks) begin
                    res.status = ST_INCOMPLETE;
                    n_open     = 1'b0;
                end else if (r_written != r_exp_bytes) begin
                    res.status = ST_MISMATCH;
                    n_open     = 1'b0;
                end else begin
                    n_open     = 1'b0;
                    n_written  = '0;
                    n_complete = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_exp_bytes  = '0;
                n_written    = '0;
                n_exp_chunks = 16'd0;
                n_rcv_chunks = 16'd0;
                n_open       = 1'b0;
                n_drop       = 1'b0;
                n_drop_code  = ST_OK;
                n_complete   = 1'b0;
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
        res.chunks   = n_rcv_chunks;
        res.open     = n_open;
        res.complete = n_complete;
    end

    // output register and skid steering
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (i_m_tready) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || i_m_tready) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_bytes  <= '0;
            r_written    <= '0;
            r_exp_chunks <= 16'd0;
            r_rcv_chunks <= 16'd0;
            r_open       <= 1'b0;
            r_drop       <= 1'b0;
            r_drop_code  <= ST_OK;
            r_complete   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_exp_bytes  <= n_exp_bytes;
                r_written    <= n_written;
                r_exp_chunks <= n_exp_chunks;
                r_rcv_chunks <= n_rcv_chunks;
                r_open       <= n_open;
                r_drop       <= n_drop;
                r_drop_code  <= n_drop_code;
                r_complete   <= n_complete;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

    // checks
    `CBTR_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CBTR_ASSERT_SAME(a_drop_has_code, i_clk, i_rst_n, r_drop, r_drop_code != ST_OK)
    `CBTR_ASSERT_SAME(a_written_in_size, i_clk, i_rst_n, 1'b1, r_written <= r_exp_bytes)
    `CBTR_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        accept && r_out_valid && !i_m_tready, r_skid_valid)

endmodule
